FILE: rtl/core/fp8c_pkg.sv
`default_nettype none
package fp8c_pkg;

  localparam int unsigned SingleWidth = 32;
  localparam int unsigned NarrowWidth = 8;
  localparam int unsigned CfgAddrWidth = 1;
  localparam int unsigned CfgDataWidth = 3;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [CfgAddrWidth-1:0] RegTargetFormat = 1'd0;
  localparam logic [CfgAddrWidth-1:0] RegRoundingMode = 1'd1;

  localparam logic FmtE4M3 = 1'b0;
  localparam logic FmtE5M2 = 1'b1;

  localparam logic [2:0] ModeRne = 3'd0;
  localparam logic [2:0] ModeRtz = 3'd1;
  localparam logic [2:0] ModeRdn = 3'd2;
  localparam logic [2:0] ModeRup = 3'd3;
  localparam logic [2:0] ModeRmm = 3'd4;
  localparam logic [2:0] ModeRno = 3'd5;

  localparam logic [6:0] E4NanMag = 7'h7f;
  localparam logic [6:0] E4MaxMag = 7'h7e;
  localparam logic [6:0] E5NanMag = 7'h7e;
  localparam logic [6:0] E5MaxMag = 7'h7b;
  localparam logic [6:0] E5InfMag = 7'h7c;

  typedef struct packed {
    logic inexact;
    logic underflow;
    logic overflow;
    logic invalid;
  } fp8c_flags_t;

  typedef struct packed {
    fp8c_flags_t flags;
    logic [NarrowWidth-1:0] narrow_word;
  } fp8c_result_t;

endpackage
`default_nettype wire

FILE: rtl/core/fp8c_convert.sv
`default_nettype none
module fp8c_convert (
  input  wire logic [31:0]    single_word,
  input  wire logic           target_format,
  input  wire logic [2:0]     rounding_mode,
  output fp8c_pkg::fp8c_result_t result
);

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic        e5;
  logic        is_nan, is_inf, is_zero, tiny;
  logic [23:0] sig;
  logic [8:0]  sh_tiny_full;
  logic [4:0]  sh_tiny, sh;
  logic [25:0] mask, rem, half, trunc_full;
  logic [4:0]  trunc, r, rn;
  logic        inx, inc, carry, ovf, to_inf;
  logic [8:0]  ex_adj, lim, be;
  logic [4:0]  hidden, max_sig;
  logic [6:0]  ovf_mag, norm_mag;

  always_comb begin
    sgn = single_word[31];
    ex  = single_word[30:23];
    fr  = single_word[22:0];
    e5  = (target_format == fp8c_pkg::FmtE5M2);
    is_nan  = (ex == 8'hff) && (fr != 23'd0);
    is_inf  = (ex == 8'hff) && (fr == 23'd0);
    is_zero = (ex == 8'd0) && (fr == 23'd0);
    sig = {ex != 8'd0, fr};
    tiny = e5 ? (ex < 8'd113) : (ex < 8'd121);

    sh_tiny_full = (e5 ? 9'd134 : 9'd141) - {1'b0, ex};
    sh_tiny = ((ex == 8'd0) || (sh_tiny_full > 9'd25)) ? 5'd25 : sh_tiny_full[4:0];
    sh = tiny ? sh_tiny : (e5 ? 5'd21 : 5'd20);

    mask = (26'd1 << sh) - 26'd1;
    rem  = {2'b00, sig} & mask;
    half = 26'd1 << (sh - 5'd1);
    trunc_full = {2'b00, sig} >> sh;
    trunc = trunc_full[4:0];
    inx = (rem != 26'd0);

    priority case (rounding_mode)
      fp8c_pkg::ModeRne: inc = (rem > half) || ((rem == half) && trunc[0]);
      fp8c_pkg::ModeRmm: inc = (rem >= half);
      fp8c_pkg::ModeRdn: inc = inx && sgn;
      fp8c_pkg::ModeRup: inc = inx && !sgn;
      default:           inc = 1'b0;
    endcase
    if (rounding_mode == fp8c_pkg::ModeRno) begin
      r = trunc | {4'd0, inx};
    end else begin
      r = trunc + {4'd0, inc};
    end

    hidden  = e5 ? 5'd4 : 5'd8;
    max_sig = e5 ? 5'd7 : 5'd14;
    carry = (r == {hidden[3:0], 1'b0});
    rn = carry ? {1'b0, r[4:1]} : r;
    ex_adj = {1'b0, ex} + {8'd0, carry};
    lim = e5 ? 9'd142 : 9'd135;
    ovf = (ex_adj > lim) || ((ex_adj == lim) && (rn > max_sig));
    be = ex_adj - (e5 ? 9'd112 : 9'd120);
    norm_mag = e5 ? {be[4:0], rn[1:0]} : {be[3:0], rn[2:0]};

    to_inf = e5 && ((rounding_mode == fp8c_pkg::ModeRne) ||
                    (rounding_mode == fp8c_pkg::ModeRmm) ||
                    ((rounding_mode == fp8c_pkg::ModeRup) && !sgn) ||
                    ((rounding_mode == fp8c_pkg::ModeRdn) && sgn));
    ovf_mag = to_inf ? fp8c_pkg::E5InfMag : (e5 ? fp8c_pkg::E5MaxMag : fp8c_pkg::E4MaxMag);

    result = '0;
    if (is_nan) begin
      result.narrow_word = {1'b0, e5 ? fp8c_pkg::E5NanMag : fp8c_pkg::E4NanMag};
      result.flags.invalid = !fr[22];
    end else if (is_inf && e5) begin
      result.narrow_word = {sgn, fp8c_pkg::E5InfMag};
    end else if (is_inf) begin
      result.narrow_word = {sgn, ovf_mag};
      result.flags.overflow = 1'b1;
      result.flags.inexact = 1'b1;
    end else if (is_zero) begin
      result.narrow_word = {sgn, 7'd0};
    end else if (tiny) begin
      result.flags.inexact = inx;
      if (r >= hidden) begin
        result.narrow_word = {sgn, 2'b00, hidden};
      end else begin
        result.narrow_word = {sgn, 2'b00, r};
        result.flags.underflow = inx;
      end
    end else if (ovf) begin
      result.narrow_word = {sgn, ovf_mag};
      result.flags.overflow = 1'b1;
      result.flags.inexact = 1'b1;
    end else begin
      result.narrow_word = {sgn, norm_mag};
      result.flags.inexact = inx;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/float32_to_fp8_converter_top.sv
`default_nettype none
// Converts one IEEE single-precision word per beat to an 8-bit float (E4M3 or
// E5M2, chosen by register 0) under one of six rounding modes (register 1),
// with invalid, overflow, underflow and inexact flags. The block accepts one
// beat every cycle while out_tready does not stall it; an accepted beat is held
// in the input register, converted by the combinational conversion logic and
// captured in the result register, which offers it on the output. Write the
// registers only while the block is empty.
module float32_to_fp8_converter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [2:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // single_word
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata   // narrow_word, flag_invalid, flag_overflow,
                                       // flag_underflow, flag_inexact, zero pad
);

  logic        fmt_r;
  logic [2:0]  mode_r;
  logic        s1_valid_r;
  logic [31:0] s1_word_r;
  logic        out_valid_r;
  fp8c_pkg::fp8c_result_t out_res_r;
  fp8c_pkg::fp8c_result_t conv_res;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= fp8c_pkg::FmtE4M3;
      mode_r <= fp8c_pkg::ModeRne;
    end else if (cfg_we) begin
      if (cfg_addr == fp8c_pkg::RegTargetFormat) begin
        fmt_r <= cfg_wdata[0];
      end else if (cfg_addr == fp8c_pkg::RegRoundingMode) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  fp8c_convert u_convert (
    .single_word   (s1_word_r),
    .target_format (fmt_r),
    .rounding_mode (mode_r),
    .result        (conv_res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_word_r <= in_tdata;
    end
    if (out_free && s1_valid_r) begin
      out_res_r <= conv_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r};

endmodule
`default_nettype wire

FILE: rtl/core/fp8c_checker.sv
`default_nettype none
module fp8c_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("stalled beat changed");

  a_unf_inexact: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[10] || out_tdata[9]) |-> out_tdata[11])
    else $error("underflow or overflow without inexact");

  a_nan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> (out_tdata[11:9] == 3'd0) && !out_tdata[7])
    else $error("invalid result carries other flags or a sign");

endmodule

bind float32_to_fp8_converter_top fp8c_checker u_fp8c_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
